// ===== hw/rtl/cpualu_pkg.sv =====
// shared types and operation codes for the 8-bit accumulator alu
package cpualu_pkg;

   localparam int unsigned KIND_W    = 5;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned BIT_IDX_W = 3;

   // operation codes carried on the kind field
   typedef enum logic [KIND_W-1:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_CP   = 5'd4,
      OP_AND  = 5'd5,
      OP_XOR  = 5'd6,
      OP_INC  = 5'd7,
      OP_DEC  = 5'd8,
      OP_SWAP = 5'd9,
      OP_RES  = 5'd10,
      OP_SET  = 5'd11,
      OP_BIT  = 5'd12,
      OP_SLA  = 5'd13,
      OP_SRL  = 5'd14,
      OP_SRA  = 5'd15,
      OP_RR   = 5'd16
   } kind_type;

   // condition flags
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   // one finished operation
   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic [DATA_W-1:0] acc;
      flags_type         flags;
   } exec_out_type;

endpackage

// ===== hw/rtl/cpualu_exec.sv =====
// combinational datapath: one alu operation against the current accumulator and flags
module cpualu_exec
   import cpualu_pkg::*;
(
   input  logic [KIND_W-1:0]    kind,
   input  logic [DATA_W-1:0]    operand,
   input  logic [BIT_IDX_W-1:0] bit_index,
   input  logic [DATA_W-1:0]    acc_cur,
   input  flags_type            flags_cur,
   output exec_out_type         exec_out
);

   logic              carry_use;
   logic [DATA_W:0]   sum_full;
   logic [4:0]        sum_nib;
   logic [DATA_W:0]   dif_full;
   logic [4:0]        dif_nib;
   logic [DATA_W-1:0] bit_mask;
   logic [DATA_W-1:0] val;

   // shared adder and subtractor, carry only for the with-carry forms
   assign carry_use = ((kind == OP_ADC) || (kind == OP_SBC)) ? flags_cur.c : 1'b0;
   assign sum_full  = {1'b0, acc_cur} + {1'b0, operand} + {{DATA_W{1'b0}}, carry_use};
   assign sum_nib   = {1'b0, acc_cur[3:0]} + {1'b0, operand[3:0]} + {4'd0, carry_use};
   assign dif_full  = {1'b0, acc_cur} - {1'b0, operand} - {{DATA_W{1'b0}}, carry_use};
   assign dif_nib   = {1'b0, acc_cur[3:0]} - {1'b0, operand[3:0]} - {4'd0, carry_use};
   assign bit_mask  = {{(DATA_W-1){1'b0}}, 1'b1} << bit_index;

   // operation select and flag rules
   always_comb begin
      val      = '0;
      exec_out = '{result: acc_cur, acc: acc_cur, flags: flags_cur};
      unique case (kind)
         OP_ADD, OP_ADC: begin
            val = sum_full[DATA_W-1:0];
            exec_out.result = val;
            exec_out.acc    = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: sum_nib[4], c: sum_full[DATA_W]};
         end
         OP_SUB, OP_SBC: begin
            val = dif_full[DATA_W-1:0];
            exec_out.result = val;
            exec_out.acc    = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b1, h: dif_nib[4], c: dif_full[DATA_W]};
         end
         OP_CP: begin
            val = dif_full[DATA_W-1:0];
            exec_out.flags = '{z: (val == '0), n: 1'b1, h: dif_nib[4], c: dif_full[DATA_W]};
         end
         OP_AND: begin
            val = acc_cur & operand;
            exec_out.result = val;
            exec_out.acc    = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            val = acc_cur ^ operand;
            exec_out.result = val;
            exec_out.acc    = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            val = operand + 8'd1;
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: (operand[3:0] == 4'hF),
                                c: flags_cur.c};
         end
         OP_DEC: begin
            val = operand - 8'd1;
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b1, h: (operand[3:0] == 4'h0),
                                c: flags_cur.c};
         end
         OP_SWAP: begin
            val = {operand[3:0], operand[7:4]};
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_RES: begin
            exec_out.result = operand & ~bit_mask;
         end
         OP_SET: begin
            exec_out.result = operand | bit_mask;
         end
         OP_BIT: begin
            exec_out.result = operand;
            exec_out.flags  = '{z: ((operand & bit_mask) == '0), n: 1'b0, h: 1'b1,
                                c: flags_cur.c};
         end
         OP_SLA: begin
            val = {operand[6:0], 1'b0};
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: operand[7]};
         end
         OP_SRL: begin
            val = {1'b0, operand[7:1]};
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: operand[0]};
         end
         OP_SRA: begin
            val = {operand[7], operand[7:1]};
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: operand[0]};
         end
         OP_RR: begin
            val = {flags_cur.c, operand[7:1]};
            exec_out.result = val;
            exec_out.flags  = '{z: (val == '0), n: 1'b0, h: 1'b0, c: operand[0]};
         end
         // unused codes: no operation, result shows the accumulator
         default: begin
            exec_out = '{result: acc_cur, acc: acc_cur, flags: flags_cur};
         end
      endcase
   end

endmodule

// ===== hw/rtl/cpu_alu_with_flags.sv =====
// top level: 8-bit accumulator alu with z/n/h/c flags
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   req     | in        | req_valid, req_stall, req_kind, req_operand,
//           |           | req_bit_index
//   rsp     | out       | rsp_valid, rsp_stall, rsp_result, rsp_accumulator,
//           |           | rsp_flag_z, rsp_flag_n, rsp_flag_h, rsp_flag_c
//
// one item per cycle sustained while rsp is not stalled; an item passes the
// input register, then the alu into the result register that also updates acc
// and flags, so each item sees the state left by the one before.
// reset clears the accumulator, the flags and both valid bits.
// req_stall rises only when both registers are full and rsp is stalled.
module cpu_alu_with_flags
   import cpualu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [DATA_W-1:0]    req_operand,
   input  logic [BIT_IDX_W-1:0] req_bit_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_W-1:0]    rsp_result,
   output logic [DATA_W-1:0]    rsp_accumulator,
   output logic                 rsp_flag_z,
   output logic                 rsp_flag_n,
   output logic                 rsp_flag_h,
   output logic                 rsp_flag_c
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]    s1_kind_ff, s1_kind_in;
   logic [DATA_W-1:0]    s1_operand_ff, s1_operand_in;
   logic [BIT_IDX_W-1:0] s1_bit_ff, s1_bit_in;
   logic [DATA_W-1:0]    acc_ff, acc_in;
   flags_type            flags_ff, flags_in;
   logic                 out_valid_ff, out_valid_in;
   exec_out_type         out_ff, out_in;

   logic                 out_free;
   logic                 s1_move;
   logic                 req_take;
   exec_out_type         exec_out;

   // handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // alu datapath
   cpualu_exec u_exec (
      .kind      (s1_kind_ff),
      .operand   (s1_operand_ff),
      .bit_index (s1_bit_ff),
      .acc_cur   (acc_ff),
      .flags_cur (flags_ff),
      .exec_out  (exec_out)
   );

   // next values for input stage, architectural state and result register
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_kind_in    = s1_kind_ff;
      s1_operand_in = s1_operand_ff;
      s1_bit_in     = s1_bit_ff;
      acc_in        = acc_ff;
      flags_in      = flags_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         out_in   = exec_out;
         acc_in   = exec_out.acc;
         flags_in = exec_out.flags;
      end
      if (req_take) begin
         s1_valid_in   = 1'b1;
         s1_kind_in    = req_kind;
         s1_operand_in = req_operand;
         s1_bit_in     = req_bit_index;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         flags_ff     <= flags_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_kind_ff    <= s1_kind_in;
      s1_operand_ff <= s1_operand_in;
      s1_bit_ff     <= s1_bit_in;
      out_ff        <= out_in;
   end

   // result channel
   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = out_ff.result;
   assign rsp_accumulator = out_ff.acc;
   assign rsp_flag_z      = out_ff.flags.z;
   assign rsp_flag_n      = out_ff.flags.n;
   assign rsp_flag_h      = out_ff.flags.h;
   assign rsp_flag_c      = out_ff.flags.c;

endmodule

// ===== hw/rtl/cpualu_checker.sv =====
// port-level checker for the alu and its bind to the top level
module cpualu_checker
   import cpualu_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [DATA_W-1:0]    rsp_result,
   input logic [DATA_W-1:0]    rsp_accumulator,
   input logic                 rsp_flag_z,
   input logic                 rsp_flag_n,
   input logic                 rsp_flag_h,
   input logic                 rsp_flag_c
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input back-pressure only when a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // an accepted item reaches the result port after the input register when rsp is not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not reach rsp");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result)
         && $stable(rsp_accumulator) && $stable(rsp_flag_z) && $stable(rsp_flag_n)
         && $stable(rsp_flag_h) && $stable(rsp_flag_c)))
      else $error("stalled rsp payload changed");

endmodule

bind cpu_alu_with_flags cpualu_checker u_cpualu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result      (rsp_result),
   .rsp_accumulator (rsp_accumulator),
   .rsp_flag_z      (rsp_flag_z),
   .rsp_flag_n      (rsp_flag_n),
   .rsp_flag_h      (rsp_flag_h),
   .rsp_flag_c      (rsp_flag_c)
);
